>>> src/ecaw_pkg.sv
// Shared types and constants for the epoch clock with active window.
// Holds command and register codes, calendar constants and the reciprocal
// factors used by the time-splitting pipeline. No dependencies.
`default_nettype none

package ecaw_pkg;

  // Millisecond prescaler
  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned PRESC_W          = $clog2(TICKS_PER_SECOND + 1);

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SYNC = 1'b1;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_UTC_OFFSET   = 2'd0,
    CFG_ACTIVE_START = 2'd1,
    CFG_ACTIVE_END   = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic signed [4:0] OFFSET_RESET = 5'sd0;
  localparam logic [4:0]        START_RESET  = 5'd0;
  localparam logic [4:0]        END_RESET    = 5'd23;

  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
  // 86400 = 128 * 675: drop the low 7 bits, then divide by 675
  localparam int unsigned DAY_LO_W      = 7;
  localparam logic [9:0]  DAY_DIV_ODD   = 10'd675;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

  // Reciprocals ceil(2^k / d); exact over the operand ranges used here
  localparam int unsigned   DAY_SHIFT = 35;
  localparam logic [25:0]   DAY_RECIP = 26'd50903317;  // d = 675,  n < 2^25
  localparam int unsigned   MIN_SHIFT = 24;
  localparam logic [18:0]   MIN_RECIP = 19'd279621;    // d = 60,   n < 86400
  localparam int unsigned   WK_SHIFT  = 19;
  localparam logic [16:0]   WK_RECIP  = 17'd74899;     // d = 7,    n < 2^16
  localparam int unsigned   HR_SHIFT  = 17;
  localparam logic [11:0]   HR_RECIP  = 12'd2185;      // d = 60,   n < 1440

  localparam logic [2:0] WD_SATURDAY = 3'd2;
  localparam logic [2:0] WD_SUNDAY   = 3'd3;

  typedef struct packed {
    logic signed [4:0] utc_offset_hours;
    logic [4:0]        active_start_hour;
    logic [4:0]        active_end_hour;
  } cfg_t;

  typedef struct packed {
    logic        synced;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] day_number;
    logic [2:0]  weekday;
    logic        active;
  } report_t;

endpackage

`default_nettype wire

>>> src/ecaw_calendar.sv
// Time-splitting pipeline: local seconds to hour, minute, second, day and
// weekday, plus the active-window flag. Six stages and an output register.
// Depends on ecaw_pkg.
`default_nettype none

module ecaw_calendar import ecaw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_epoch,
  input  wire logic        in_synced,
  output logic             out_valid,
  input  wire logic        out_stall,
  output report_t          out_report
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] prev_v;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    prev_v = {v_r[NSTG-2:0], in_valid};
    for (int k = 0; k < NSTG; k++) begin
      v_nxt[k] = rdy[k] ? prev_v[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

  // stage b: local seconds
  logic signed [31:0] offset_secs;
  logic               syn_b_r;
  logic [31:0]        t_b_r;

  assign offset_secs = 32'(32'(signed'(cfg.utc_offset_hours)) *
                           signed'({20'd0, SECS_PER_HOUR}));

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      syn_b_r <= in_synced;
      t_b_r   <= in_epoch + unsigned'(offset_secs);
    end
  end

  // stage c: day estimate product
  logic        syn_c_r;
  logic [31:0] t_c_r;
  logic [50:0] p1_c_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      syn_c_r <= syn_b_r;
      t_c_r   <= t_b_r;
      p1_c_r  <= t_b_r[31:DAY_LO_W] * DAY_RECIP;
    end
  end

  // stage d: day number and seconds of day
  logic [15:0] day_d;
  logic [24:0] rem_d;
  logic        syn_d_r;
  logic [15:0] day_d_r;
  logic [16:0] sod_d_r;

  assign day_d = p1_c_r[DAY_SHIFT+15:DAY_SHIFT];
  assign rem_d = t_c_r[31:DAY_LO_W] - 25'(day_d * DAY_DIV_ODD);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      syn_d_r <= syn_c_r;
      day_d_r <= day_d;
      sod_d_r <= {rem_d[9:0], t_c_r[DAY_LO_W-1:0]};
    end
  end

  // stage e: minute-of-day and week products
  logic        syn_e_r;
  logic [15:0] day_e_r;
  logic [16:0] sod_e_r;
  logic [35:0] p2_e_r;
  logic [32:0] p3_e_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      syn_e_r <= syn_d_r;
      day_e_r <= day_d_r;
      sod_e_r <= sod_d_r;
      p2_e_r  <= sod_d_r * MIN_RECIP;
      p3_e_r  <= day_d_r * WK_RECIP;
    end
  end

  // stage f: minute of day, second, weekday
  logic [10:0] mt_f;
  logic [13:0] wk_f;
  logic        syn_f_r;
  logic [15:0] day_f_r;
  logic [10:0] mt_f_r;
  logic [5:0]  sec_f_r;
  logic [2:0]  wd_f_r;

  assign mt_f = p2_e_r[MIN_SHIFT+10:MIN_SHIFT];
  assign wk_f = p3_e_r[WK_SHIFT+13:WK_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      syn_f_r <= syn_e_r;
      day_f_r <= day_e_r;
      mt_f_r  <= mt_f;
      sec_f_r <= 6'(sod_e_r - 17'(mt_f * SECS_PER_MIN));
      wd_f_r  <= 3'(day_e_r - 16'(wk_f * DAYS_PER_WEEK));
    end
  end

  // stage g: hour product
  logic        syn_g_r;
  logic [15:0] day_g_r;
  logic [10:0] mt_g_r;
  logic [5:0]  sec_g_r;
  logic [2:0]  wd_g_r;
  logic [22:0] p4_g_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      syn_g_r <= syn_f_r;
      day_g_r <= day_f_r;
      mt_g_r  <= mt_f_r;
      sec_g_r <= sec_f_r;
      wd_g_r  <= wd_f_r;
      p4_g_r  <= mt_f_r * HR_RECIP;
    end
  end

  // output register: hour, minute, window check; zero everything until synced
  logic [4:0] hour_g;
  logic [5:0] min_g;
  logic       act_g;
  report_t    rep_nxt;
  report_t    rep_r;

  assign hour_g = p4_g_r[HR_SHIFT+4:HR_SHIFT];
  assign min_g  = 6'(mt_g_r - 11'(hour_g * MINS_PER_HOUR));
  assign act_g  = (wd_g_r != WD_SATURDAY) && (wd_g_r != WD_SUNDAY) &&
                  (hour_g >= cfg.active_start_hour) &&
                  (hour_g <= cfg.active_end_hour);

  always_comb begin
    rep_nxt        = '0;
    rep_nxt.synced = syn_g_r;
    if (syn_g_r) begin
      rep_nxt.hour       = hour_g;
      rep_nxt.minute     = min_g;
      rep_nxt.second     = sec_g_r;
      rep_nxt.day_number = day_g_r;
      rep_nxt.weekday    = wd_g_r;
      rep_nxt.active     = act_g;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      rep_r <= rep_nxt;
    end
  end

  assign out_report = rep_r;

endmodule

`default_nettype wire

>>> src/epoch_clock_with_active_window_core.sv
// Throughput: one beat per cycle while the out channel does not stall; the
// clock state updates at accept and the split into calendar fields runs
// in a 7-register pipeline.
// Reset (synchronous, rst_n low): clock unsynced, seconds and prescaler
// cleared, pipeline empty, offset 0, window 0..23.
// Top level: clock state, configuration registers, and ecaw_calendar.
// Depends on ecaw_pkg and ecaw_calendar.
`default_nettype none

module epoch_clock_with_active_window_core import ecaw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_cmd,
  input  wire logic [31:0]           in_epoch_seconds,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_synced,
  output logic [4:0]                 out_hour,
  output logic [5:0]                 out_minute,
  output logic [5:0]                 out_second,
  output logic [15:0]                out_day_number,
  output logic [2:0]                 out_weekday,
  output logic                       out_active
);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.utc_offset_hours  <= OFFSET_RESET;
      cfg_r.active_start_hour <= START_RESET;
      cfg_r.active_end_hour   <= END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UTC_OFFSET:   cfg_r.utc_offset_hours  <= signed'(cfg_wdata);
        CFG_ACTIVE_START: cfg_r.active_start_hour <= cfg_wdata;
        CFG_ACTIVE_END:   cfg_r.active_end_hour   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clock state
  logic               synced_r;
  logic [31:0]        epoch_r, epoch_nxt;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic [PRESC_W:0]   presc_inc;
  logic               acc;

  logic        a_v_r;
  logic        a_syn_r;
  logic [31:0] a_epoch_r;
  logic        cal_ready;

  assign in_stall  = a_v_r && !cal_ready;
  assign acc       = in_valid && !in_stall;
  assign presc_inc = {1'b0, presc_r} + 1'b1;

  always_comb begin
    epoch_nxt = epoch_r;
    presc_nxt = presc_r;
    if (in_cmd == CMD_SYNC) begin
      epoch_nxt = in_epoch_seconds;
      presc_nxt = '0;
    end else if (presc_inc >= (PRESC_W + 1)'(TICKS_PER_SECOND)) begin
      // roll over: advance one second
      presc_nxt = '0;
      epoch_nxt = epoch_r + 32'd1;
    end else begin
      presc_nxt = presc_inc[PRESC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r <= 1'b0;
      epoch_r  <= '0;
      presc_r  <= '0;
      a_v_r    <= 1'b0;
    end else begin
      if (acc) begin
        synced_r <= synced_r || (in_cmd == CMD_SYNC);
        epoch_r  <= epoch_nxt;
        presc_r  <= presc_nxt;
        a_v_r    <= 1'b1;
      end else if (cal_ready) begin
        a_v_r <= 1'b0;
      end
    end
  end

  // hold the post-update state of the beat for the calendar pipeline
  always_ff @(posedge clk) begin
    if (acc) begin
      a_syn_r   <= synced_r || (in_cmd == CMD_SYNC);
      a_epoch_r <= epoch_nxt;
    end
  end

  report_t rep;

  ecaw_calendar u_cal (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (a_v_r),
    .in_ready   (cal_ready),
    .in_epoch   (a_epoch_r),
    .in_synced  (a_syn_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_report (rep)
  );

  assign out_synced     = rep.synced;
  assign out_hour       = rep.hour;
  assign out_minute     = rep.minute;
  assign out_second     = rep.second;
  assign out_day_number = rep.day_number;
  assign out_weekday    = rep.weekday;
  assign out_active     = rep.active;

endmodule

`default_nettype wire

>>> src/ecaw_checker.sv
// Port-level checks for epoch_clock_with_active_window_core, bound to
// every instance of the top level. Depends on ecaw_pkg.
`default_nettype none

module ecaw_checker import ecaw_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_synced,
  input wire logic [4:0]            out_hour,
  input wire logic [5:0]            out_minute,
  input wire logic [5:0]            out_second,
  input wire logic [15:0]           out_day_number,
  input wire logic [2:0]            out_weekday,
  input wire logic                  out_active
);

  // a reset cycle leaves no report pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid right after reset");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < 5'd24) && (out_minute < 6'd60) &&
                  (out_second < 6'd60) && (out_weekday < DAYS_PER_WEEK))
    else $error("calendar field out of range");

  a_unsynced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_synced) |-> (out_hour == '0) && (out_minute == '0) &&
      (out_second == '0) && (out_day_number == '0) && (out_weekday == '0) &&
      !out_active)
    else $error("time fields nonzero before sync");

  a_active_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_active) |-> out_synced && (out_weekday != WD_SATURDAY) &&
      (out_weekday != WD_SUNDAY))
    else $error("active flag on weekend or unsynced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_synced) &&
      $stable(out_hour) && $stable(out_minute) && $stable(out_second) &&
      $stable(out_day_number) && $stable(out_weekday) && $stable(out_active))
    else $error("stalled report changed");

endmodule

bind epoch_clock_with_active_window_core ecaw_checker u_ecaw_checker (.*);

`default_nettype wire
